// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [DataW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [1:0]              status;
    logic                    now_full;
    logic                    now_empty;
  } rsp_t;

  // ring access issued with an accepted transaction
  typedef struct packed {
    logic             we;
    logic [PtrW-1:0]  waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [PtrW-1:0]  raddr;
  } mem_req_t;

  // result waiting for the ring read data
  typedef struct packed {
    logic use_mem;
    rsp_t rsp;
  } pend_t;

endpackage

// ===== sv/cdq_ram.sv =====
module cdq_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cdq_ctrl.sv =====
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  req_t     req_i,
  output mem_req_t mem_o,
  output pend_t    res_o
);

  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic            empty_q, empty_d;
  logic            is_full;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) r = '0;
    else                       r = p + PtrW'(1);
    return r;
  endfunction

  function automatic logic [PtrW-1:0] ptr_prev(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == '0) r = PtrW'(Depth - 1);
    else         r = p - PtrW'(1);
    return r;
  endfunction

  assign is_full = !empty_q && (ptr_next(tail_q) == head_q);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    mem_o   = '0;
    res_o   = '0;
    mem_o.wdata = req_i.data_in;
    res_o.rsp.status = ST_DONE;
    unique case (req_i.op) inside
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (is_full) begin
          res_o.rsp.status = ST_FULL;
        end else begin
          mem_o.we = 1'b1;
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
            mem_o.waddr = '0;
          end else if (req_i.op == OP_PUSH_FRONT) begin
            head_d = ptr_prev(head_q);
            mem_o.waddr = head_d;
          end else begin
            tail_d = ptr_next(tail_q);
            mem_o.waddr = tail_d;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (empty_q) begin
          res_o.rsp.status   = ST_EMPTY;
          res_o.rsp.data_out = '1;
        end else begin
          mem_o.re      = 1'b1;
          res_o.use_mem = 1'b1;
          if (req_i.op == OP_POP_FRONT || req_i.op == OP_PEEK_FRONT) begin
            mem_o.raddr = head_q;
          end else begin
            mem_o.raddr = tail_q;
          end
          if (req_i.op == OP_POP_FRONT || req_i.op == OP_POP_REAR) begin
            if (head_q == tail_q) begin
              // last element leaves
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else if (req_i.op == OP_POP_FRONT) begin
              head_d = ptr_next(head_q);
            end else begin
              tail_d = ptr_prev(tail_q);
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_o.rsp.now_empty = empty_d;
    res_o.rsp.now_full  = !empty_d && (ptr_next(tail_d) == head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

endmodule

// ===== sv/circular_deque_unit.sv =====
// a result passes from the pending register to the output register after its transaction is accepted
// throughput: one transaction per cycle while the output is not stalled
// the ring store has one write and one read port; the read data comes back in the cycle after the read
// one accepted transaction waits in the pending register while a finished result sits in the output register
// reset: asynchronous, active low; the deque comes up empty with both pointers at zero
module circular_deque_unit
  import cdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  mem_req_t         mem_req;
  pend_t            pend_d;
  pend_t            pend_q;
  logic             pend_valid_q;
  logic             pend_move;
  logic             accept;
  logic [DataW-1:0] rdata;
  logic             out_valid_q;
  rsp_t             out_q;

  assign pend_move  = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_valid_q && !pend_move;
  assign accept     = in_valid_i && !in_stall_o;

  cdq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .mem_o    (mem_req),
    .res_o    (pend_d)
  );

  cdq_ram #(
    .Depth (Depth),
    .Width (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (accept && mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
    if (pend_move) begin
      out_q <= pend_q.rsp;
      // ring data still held from the read issued at acceptance
      if (pend_q.use_mem) begin
        out_q.data_out <= rdata;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== tb/circular_deque_unit_test.sv =====
`timescale 1ns / 100ps

module circular_deque_unit_test;
  import cdq_pkg::*;

  // opcodes 6 and 7 are unassigned and leave the deque alone
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int QuietLimit   = 2000;
  localparam int HoldOffLen   = 80;
  localparam int PhaseItems   = 384;
  localparam int BurstLen     = 24;
  localparam int MaxPrinted   = 100;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] data;
    int          reps;
    bit          typed;
    rsp_t        want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_rsp_o;

  // shadow deque state
  logic [DataW-1:0] ring_words [Depth];
  logic [PtrW-1:0]  dq_head;
  logic [PtrW-1:0]  dq_tail;
  logic             dq_empty;

  rsp_t      deque_answers [$];
  step_row_t directed_rows [$];

  int mismatches     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 13;
  int recv_idle_pct  = 61;
  int hold_off_asked = 0;

  circular_deque_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ptr_prev(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(Depth - 1) : p - 1'b1;
  endfunction

  function automatic logic deque_full();
    return !dq_empty && (ptr_next(dq_tail) == dq_head);
  endfunction

  // applies one transaction to the shadow deque and returns its answer
  function automatic rsp_t deque_apply(input req_t r);
    rsp_t a;
    logic at_front;
    a = '0;
    a.status = ST_DONE;
    at_front = (r.op == OP_POP_FRONT) || (r.op == OP_PEEK_FRONT);
    case (r.op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (deque_full()) begin
          a.status = ST_FULL;
        end else begin
          if (dq_empty) begin
            dq_head  = '0;
            dq_tail  = '0;
            dq_empty = 1'b0;
          end else if (r.op == OP_PUSH_FRONT) begin
            dq_head = ptr_prev(dq_head);
          end else begin
            dq_tail = ptr_next(dq_tail);
          end
          ring_words[(r.op == OP_PUSH_FRONT) ? dq_head : dq_tail] = r.data_in;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (dq_empty) begin
          a.status   = ST_EMPTY;
          a.data_out = -1;
        end else begin
          a.data_out = ring_words[at_front ? dq_head : dq_tail];
          if (r.op == OP_POP_FRONT || r.op == OP_POP_REAR) begin
            // last element leaves: pointers go home
            if (dq_head == dq_tail) begin
              dq_head  = '0;
              dq_tail  = '0;
              dq_empty = 1'b1;
            end else if (at_front) begin
              dq_head = ptr_next(dq_head);
            end else begin
              dq_tail = ptr_prev(dq_tail);
            end
          end
        end
      end
      default: ;
    endcase
    a.now_full  = deque_full();
    a.now_empty = dq_empty;
    return a;
  endfunction

  function automatic req_t pick_request(input int push_pct);
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    case ($urandom_range(7))
      0:       r.data_in = 32'h7FFF_FFFF;
      1:       r.data_in = 32'h8000_0000;
      2:       r.data_in = 32'h0000_0000;
      3:       r.data_in = 32'hFFFF_FFFF;
      default: r.data_in = $urandom;
    endcase
    if (roll < 3) begin
      r.op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
    end else if (roll < 3 + push_pct) begin
      r.op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    end else begin
      case ($urandom_range(5))
        0, 1:    r.op = OP_POP_FRONT;
        2, 3:    r.op = OP_POP_REAR;
        4:       r.op = OP_PEEK_FRONT;
        default: r.op = OP_PEEK_REAR;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic add_row(input logic [2:0] op, input logic [31:0] data, input int reps,
                         input bit typed, input logic [31:0] d, input logic [1:0] st,
                         input logic full, input logic empty);
    step_row_t row;
    row.op   = op;
    row.data = data;
    row.reps = reps;
    row.typed = typed;
    row.want.data_out  = d;
    row.want.status    = st;
    row.want.now_full  = full;
    row.want.now_empty = empty;
    directed_rows.push_back(row);
  endtask

  // offers one transaction and returns at the edge that accepts it
  task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    predicted = deque_apply(r);
    deque_answers.push_back(typed ? typed_rsp : predicted);
  endtask

  initial begin : stimulus
    step_row_t row;
    req_t      r;
    int        push_pct;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    foreach (ring_words[i]) ring_words[i] = '0;
    dq_head  = '0;
    dq_tail  = '0;
    dq_empty = 1'b1;

    // refusals on an empty deque, then an unassigned opcode
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1'b0, 1'b1);
    add_row(OP_POP_REAR,   32'h1234_5678, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1'b0, 1'b1);
    add_row(OP_PEEK_FRONT, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1'b0, 1'b1);
    add_row(OP_PEEK_REAR,  32'h8000_0000, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1'b0, 1'b1);
    add_row(OP_RSVD6,      32'hFFFF_FFFF, 1, 1, 32'h0000_0000, ST_DONE,  1'b0, 1'b1);
    // single element in and out from either end
    add_row(OP_PUSH_REAR,  32'h8000_0000, 1, 1, 32'h0000_0000, ST_DONE,  1'b0, 1'b0);
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, 1, 32'h8000_0000, ST_DONE,  1'b0, 1'b1);
    add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 32'h0000_0000, ST_DONE,  1'b0, 1'b0);
    add_row(OP_POP_REAR,   32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_DONE,  1'b0, 1'b1);
    // fill to the brim, then pushes are refused, then both ends are read back
    add_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1, 32'h0000_0000, ST_DONE,  1'b0, 1'b0);
    add_row(OP_PUSH_REAR,  32'h0000_0000, Depth - 1, 0, '0, ST_DONE, 1'b0, 1'b0);
    add_row(OP_PUSH_FRONT, 32'h5A5A_5A5A, 1, 1, 32'h0000_0000, ST_FULL,  1'b1, 1'b0);
    add_row(OP_PUSH_REAR,  32'hA5A5_A5A5, 1, 1, 32'h0000_0000, ST_FULL,  1'b1, 1'b0);
    add_row(OP_RSVD7,      32'h0000_0000, 1, 1, 32'h0000_0000, ST_DONE,  1'b1, 1'b0);
    add_row(OP_PEEK_FRONT, 32'h0000_0000, 1, 1, 32'h7FFF_FFFF, ST_DONE,  1'b1, 1'b0);
    add_row(OP_PEEK_REAR,  32'h0000_0000, 1, 0, '0, ST_DONE, 1'b0, 1'b0);
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, 1, 32'h7FFF_FFFF, ST_DONE,  1'b0, 1'b0);
    add_row(OP_POP_REAR,   32'h0000_0000, 1, 0, '0, ST_DONE, 1'b0, 1'b0);
    add_row(OP_PUSH_FRONT, 32'h0000_0001, 1, 0, '0, ST_DONE, 1'b0, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      for (int k = 0; k < row.reps; k++) begin
        r.op      = row.op;
        r.data_in = row.data + k;
        send_req(r, row.typed, row.want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 13;
          recv_idle_pct <= 61;
        end
        1: begin
          send_idle_pct <= 61;
          recv_idle_pct <= 13;
        end
        default: begin
          send_idle_pct  <= 0;
          recv_idle_pct  <= 0;
          // receiver holds off while the sender keeps offering
          hold_off_asked <= hold_off_asked + 1;
        end
      endcase
      push_pct = 45;
      for (int i = 0; i < PhaseItems; i++) begin
        // bursts lean toward filling or draining so both ends get hit
        if (i % BurstLen == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 70;
            1:       push_pct = 20;
            default: push_pct = 45;
          endcase
        end
        send_req(pick_request(push_pct), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (deque_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : receiver
    int stretch;
    int holds_done;
    stretch     = 0;
    holds_done  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stretch == 0 && holds_done < hold_off_asked) begin
        stretch = HoldOffLen;
        holds_done++;
      end
      if (stretch > 0) begin
        stretch--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : answer_check
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deque_answers.size() == 0) begin
        report_mismatch("result with nothing expected", out_rsp_o.data_out, '0);
      end else begin
        want = deque_answers.pop_front();
        if (out_rsp_o.data_out !== want.data_out)
          report_mismatch("data_out", out_rsp_o.data_out, want.data_out);
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        if (out_rsp_o.now_full !== want.now_full)
          report_mismatch("now_full", 32'(out_rsp_o.now_full), 32'(want.now_full));
        if (out_rsp_o.now_empty !== want.now_empty)
          report_mismatch("now_empty", 32'(out_rsp_o.now_empty), 32'(want.now_empty));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
